### hw/rtl/sync_length_packet_deframer_assert.svh
// Assertion macros for the packet deframer.
// Clocked on clock, disabled during reset; no other dependencies.
`ifndef SYNC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define SLD_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sld assertion failed");

// next-cycle implication
`define SLD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sld assertion failed");

`endif

### hw/rtl/sld_pkg.sv
// Shared types and constants for the sync/length packet deframer.
// No dependencies.
package sld_pkg;

   localparam int HEADER_BYTES = 4;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 16;
   localparam int LEFT_W = 17;
   localparam int IDX_W  = 2;

   localparam logic [LEFT_W-1:0] EXTRA_BYTES = LEFT_W'(HEADER_BYTES - 4);

   localparam logic [IDX_W-1:0] IDX_FIRST  = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_LEN_LO = IDX_W'(2);
   localparam logic [IDX_W-1:0] IDX_LEN_HI = IDX_W'(3);

   localparam logic [0:0] CSR_SYNC_BYTE   = 1'b0;
   localparam logic [0:0] CSR_MAX_PAYLOAD = 1'b1;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = '1;

   typedef enum logic [2:0] {
      PH_HUNT = 3'b001,
      PH_HEAD = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   typedef struct packed {
      logic              sync_valid;
      logic [BYTE_W-1:0] sync_byte;
      logic [LEN_W-1:0]  max_payload;
   } csr_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] out_byte;
      logic              first_of_packet;
      logic              last_of_packet;
      logic              length_error;
   } result_type;

endpackage

### hw/rtl/sld_csr.sv
// Configuration registers: sync byte and maximum payload length.
// Depends on sld_pkg.
module sld_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [0:0]                 csr_addr,
   input  logic [sld_pkg::LEN_W-1:0]  csr_wdata,
   output sld_pkg::csr_type           csr
);
   import sld_pkg::*;

   logic [BYTE_W-1:0] sync_byte_ff, sync_byte_in;
   logic [LEN_W-1:0]  max_payload_ff, max_payload_in;

   always_comb begin
      sync_byte_in   = sync_byte_ff;
      max_payload_in = max_payload_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_SYNC_BYTE:   sync_byte_in   = csr_wdata[BYTE_W-1:0];
            CSR_MAX_PAYLOAD: max_payload_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_byte_ff   <= '0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         sync_byte_ff   <= sync_byte_in;
         max_payload_ff <= max_payload_in;
      end
   end

   assign csr.sync_valid  = 1'b1;
   assign csr.sync_byte   = sync_byte_ff;
   assign csr.max_payload = max_payload_ff;

endmodule

### hw/rtl/sld_fsm.sv
// Framing state machine: hunt, header and body phases with length count.
// Produces one result per stepped byte, combinationally. Depends on sld_pkg.
module sld_fsm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [sld_pkg::BYTE_W-1:0]  data_byte,
   input  sld_pkg::csr_type            csr,
   output sld_pkg::result_type         result
);
   import sld_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [BYTE_W-1:0]  len_lo_ff, len_lo_in;
   logic [LEFT_W-1:0]  left_ff, left_in;
   logic [LEN_W-1:0]   len;
   logic [LEFT_W-1:0]  left_init;
   logic [LEFT_W-1:0]  left_dec;

   assign len       = {data_byte, len_lo_ff};
   assign left_init = {1'b0, len} + EXTRA_BYTES;
   assign left_dec  = left_ff - LEFT_W'(1);

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      len_lo_in = len_lo_ff;
      left_in   = left_ff;
      result.valid           = 1'b0;
      result.out_byte        = data_byte;
      result.first_of_packet = 1'b0;
      result.last_of_packet  = 1'b0;
      result.length_error    = 1'b0;
      case (phase_ff)
         PH_HEAD: begin
            result.valid = 1'b1;
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_LEN_LO) begin
               len_lo_in = data_byte;
            end else if (idx_ff == IDX_LEN_HI) begin
               if (len > csr.max_payload) begin
                  phase_in = PH_HUNT;
                  left_in  = '0;
                  result.last_of_packet = 1'b1;
                  result.length_error   = 1'b1;
               end else if (left_init == '0) begin
                  phase_in = PH_HUNT;
                  left_in  = '0;
                  result.last_of_packet = 1'b1;
               end else begin
                  phase_in = PH_BODY;
                  left_in  = left_init;
               end
            end
         end
         PH_BODY: begin
            result.valid = 1'b1;
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_HUNT;
               result.last_of_packet = 1'b1;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            if (csr.sync_valid && data_byte == csr.sync_byte) begin
               phase_in  = PH_HEAD;
               idx_in    = IDX_FIRST;
               len_lo_in = '0;
               left_in   = '0;
               result.valid           = 1'b1;
               result.first_of_packet = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         idx_ff    <= '0;
         len_lo_ff <= '0;
         left_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         len_lo_ff <= len_lo_in;
         left_ff   <= left_in;
      end
   end

endmodule

### hw/rtl/sync_length_packet_deframer.sv
// Sync/length packet deframer top level: input register, framing FSM, result register.
// The rsp transfer of a packet byte follows its req transfer through the input register, then the result register.
// Throughput: one byte per cycle unless the rsp side stalls; the single framing FSM updates once per byte.
// Hunted junk bytes produce no rsp transfer.
// Reset (synchronous, active high) empties both registers and returns to hunting.
// Depends on sld_pkg, sld_csr, sld_fsm and the assertion macro header.
`include "sync_length_packet_deframer_assert.svh"
module sync_length_packet_deframer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] data_byte
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] out_byte
   output logic                       rsp_tlast,
   output logic [1:0]                 rsp_tuser,   // [0] first_of_packet, [1] length_error
   input  logic                       csr_we,
   input  logic [0:0]                 csr_addr,
   input  logic [sld_pkg::LEN_W-1:0]  csr_wdata
);
   import sld_pkg::*;

   csr_type           csr;
   result_type        result;
   logic              in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0] in_data_ff;
   logic              out_vld_ff, out_vld_in;
   result_type        out_ff;
   logic              advance;
   logic              req_fire;

   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   sld_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   sld_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_data_ff),
      .csr       (csr),
      .result    (result)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_fire) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = result.valid;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff.out_byte;
   assign rsp_tlast  = out_ff.last_of_packet;
   assign rsp_tuser  = {out_ff.length_error, out_ff.first_of_packet};

   `SLD_ASSERT_SAME(a_err_is_last, rsp_tvalid && rsp_tuser[1], rsp_tlast)
   `SLD_ASSERT_SAME(a_first_not_last, rsp_tvalid && rsp_tuser[0], !rsp_tlast && !rsp_tuser[1])
   `SLD_ASSERT_NEXT(a_held_input_kept, in_vld_ff && !advance, in_vld_ff)
   `SLD_ASSERT_NEXT(a_accept_fills, req_tvalid && req_tready, in_vld_ff)

endmodule

### tb/sync_length_packet_deframer_test.sv
// Testbench for sync_length_packet_deframer: random bursty byte streams of framed packets,
// junk and broken frames, checked byte by byte against a framing tracker.
// Depends on sld_pkg and the deframer RTL.
module sync_length_packet_deframer_test;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned LEN_LO_POS = 2;
   localparam int unsigned LEN_HI_POS = 3;
   localparam int unsigned DRAIN_CYCLES = 6;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       err;
   } packet_byte_type;

   class framing_tracker;
      logic [7:0]          sync_byte = 8'h00;
      logic [15:0]         max_payload = 16'hFFFF;
      sld_pkg::phase_type  phase = sld_pkg::PH_HUNT;
      logic [7:0]          header_pos = 8'd0;
      logic [7:0]          length_low = 8'd0;
      logic [16:0]         bytes_left = 17'd0;
      packet_byte_type     expected_bytes[$];
      int unsigned         errors = 0;

      function void set_register(logic [0:0] addr, logic [15:0] value);
         case (addr)
            sld_pkg::CSR_SYNC_BYTE:   sync_byte = value[7:0];
            sld_pkg::CSR_MAX_PAYLOAD: max_payload = value;
            default: ;
         endcase
      endfunction

      function void push(logic [7:0] b, logic first, logic last, logic err);
         packet_byte_type item;
         item.data = b;
         item.first = first;
         item.last = last;
         item.err = err;
         expected_bytes = {expected_bytes, item};
      endfunction

      // returns 1 when the byte causes an output transfer
      function bit note_byte(logic [7:0] b);
         logic [7:0]  pos;
         logic [16:0] len;
         case (phase)
            sld_pkg::PH_HEAD: begin
               pos = header_pos;
               header_pos = header_pos + 8'd1;
               if (pos == LEN_LO_POS) begin
                  length_low = b;
                  push(b, 1'b0, 1'b0, 1'b0);
               end else if (pos == LEN_HI_POS) begin
                  len = {1'b0, b, length_low};
                  if (len[15:0] > max_payload) begin
                     phase = sld_pkg::PH_HUNT;
                     header_pos = 8'd0;
                     bytes_left = 17'd0;
                     push(b, 1'b0, 1'b1, 1'b1);
                  end else begin
                     bytes_left = len + 17'(sld_pkg::HEADER_BYTES - 4);
                     if (bytes_left == 17'd0) begin
                        phase = sld_pkg::PH_HUNT;
                        header_pos = 8'd0;
                        push(b, 1'b0, 1'b1, 1'b0);
                     end else begin
                        phase = sld_pkg::PH_BODY;
                        push(b, 1'b0, 1'b0, 1'b0);
                     end
                  end
               end else begin
                  push(b, 1'b0, 1'b0, 1'b0);
               end
               return 1'b1;
            end
            sld_pkg::PH_BODY: begin
               bytes_left = bytes_left - 17'd1;
               if (bytes_left == 17'd0) begin
                  phase = sld_pkg::PH_HUNT;
                  header_pos = 8'd0;
                  push(b, 1'b0, 1'b1, 1'b0);
               end else begin
                  push(b, 1'b0, 1'b0, 1'b0);
               end
               return 1'b1;
            end
            default: begin
               phase = sld_pkg::PH_HUNT;
               if (b == sync_byte) begin
                  phase = sld_pkg::PH_HEAD;
                  header_pos = 8'd1;
                  length_low = 8'd0;
                  bytes_left = 17'd0;
                  push(b, 1'b1, 1'b0, 1'b0);
                  return 1'b1;
               end
               return 1'b0;
            end
         endcase
      endfunction

      function void check_byte(packet_byte_type got);
         packet_byte_type want;
         if (expected_bytes.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected output: data %h first %b last %b err %b",
                        got.data, got.first, got.last, got.err);
            return;
         end
         want = expected_bytes.pop_front();
         if (got.data !== want.data || got.first !== want.first ||
             got.last !== want.last || got.err !== want.err) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected data %h first %b last %b err %b, got %h %b %b %b",
                        want.data, want.first, want.last, want.err,
                        got.data, got.first, got.last, got.err);
         end
      endfunction

      function int unsigned pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_addr = sld_pkg::CSR_SYNC_BYTE;
   logic [15:0] csr_wdata = 16'h0000;

   framing_tracker tracker = new();
   int unsigned    burst_left = 0;
   int unsigned    sent = 0;
   int unsigned    cycle_count = 0;
   logic [31:0]    ready_bits = '1;
   int unsigned    ready_pos = 0;

   sync_length_packet_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver: 32-bit stall pattern, drawn anew once all its bits are used
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_byte({rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]});
      if (ready_pos == 0) begin
         case ($urandom_range(0, 3))
            0: ready_bits = '1;
            1: ready_bits = $urandom | $urandom;
            2: ready_bits = $urandom;
            default: ready_bits = ($urandom & $urandom) | 32'h1;
         endcase
      end
      rsp_tready <= ready_bits[ready_pos];
      ready_pos = (ready_pos + 1) % 32;
   end

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      void'(tracker.note_byte(b));
      sent++;
   endtask

   // hold off input until every expected transfer has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic [7:0] sync, input logic [15:0] max_len);
      logic [15:0] sync_word;
      sync_word = {8'($urandom), sync};
      csr_we <= 1'b1;
      csr_addr <= sld_pkg::CSR_SYNC_BYTE;
      csr_wdata <= sync_word;
      @(posedge clock);
      tracker.set_register(sld_pkg::CSR_SYNC_BYTE, sync_word);
      csr_addr <= sld_pkg::CSR_MAX_PAYLOAD;
      csr_wdata <= max_len;
      @(posedge clock);
      tracker.set_register(sld_pkg::CSR_MAX_PAYLOAD, max_len);
      csr_we <= 1'b0;
   endtask

   task automatic send_packet();
      int unsigned kind;
      int unsigned len;
      int unsigned max_len;
      logic [7:0]  sync;
      sync = tracker.sync_byte;
      max_len = tracker.max_payload;
      kind = $urandom_range(0, 99);
      send_byte(sync);
      if (kind < 8) begin
         // broken frame: header cut short, following bytes fall into it
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
         return;
      end
      case ($urandom_range(0, 9))
         0: len = (max_len < 65535) ? max_len + 1 : $urandom_range(0, 24);
         1: len = (max_len <= 64) ? max_len : $urandom_range(0, 24);
         2: begin
            len = $urandom_range(0, 65535);
            if (len <= max_len && len > 64)
               len = len % 48;
         end
         3: len = 0;
         default: len = $urandom_range(0, 24);
      endcase
      send_byte(8'($urandom));
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      if (len <= max_len) begin
         repeat (len + sld_pkg::HEADER_BYTES - 4)
            send_byte(($urandom_range(0, 7) == 0) ? sync : 8'($urandom));
      end
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
   endtask

   initial begin
      logic [7:0]  opening[] = '{8'hFF, 8'h5A,
                                 8'h00, 8'hFF, 8'h00, 8'h00,
                                 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'hFF,
                                 8'h00, 8'h11, 8'h01, 8'h00, 8'h80};
      logic [7:0]  oversize[] = '{8'hFF, 8'h00, 8'h01, 8'h00,
                                  8'hFF, 8'h12, 8'hFF, 8'hFF,
                                  8'hFF, 8'h34, 8'h00, 8'h00};
      int unsigned quota[6] = '{230, 140, 280, 230, 230, 90};
      int unsigned goal;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (opening[i]) send_byte(opening[i]);
      for (int mode = 0; mode < 6; mode++) begin
         if (mode > 0) begin
            drain();
            case (mode)
               1: set_mode(8'hFF, 16'h0000);
               2: set_mode(8'hA5, 16'd16);
               3: set_mode(8'($urandom), 16'($urandom_range(0, 40)));
               4: set_mode(8'($urandom), 16'($urandom));
               default: set_mode(8'h00, 16'hFFFF);
            endcase
         end
         if (mode == 1)
            foreach (oversize[i]) send_byte(oversize[i]);
         goal = sent + quota[mode];
         while (sent < goal) send_packet();
      end
      drain();
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/sld_pkg.sv
hw/rtl/sld_csr.sv
hw/rtl/sld_fsm.sv
hw/rtl/sync_length_packet_deframer.sv
tb/sync_length_packet_deframer_test.sv
